@@ hw/rtl/sitda_pkg.sv @@
// Shared types and constants for the signed integer to decimal text converter.
package sitda_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W = 7;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 7'h39;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/sitda_cell.sv @@
// One decimal digit cell of the shift-and-add-3 converter row.
module sitda_cell (
    input  logic                          clk,
    input  sitda_pkg::cell_ctrl_t         ctrl,
    input  logic                          bit_in,
    output logic                          bit_out,
    input  logic [sitda_pkg::DIGIT_W-1:0] digit_in,
    output logic [sitda_pkg::DIGIT_W-1:0] digit
);

    logic [sitda_pkg::DIGIT_W-1:0] digit_reg;
    logic [sitda_pkg::DIGIT_W-1:0] digit_next;
    logic [sitda_pkg::DIGIT_W-1:0] adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        bit_out = adj[sitda_pkg::DIGIT_W-1];
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[sitda_pkg::DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii.sv @@
// Top level of the signed integer to decimal ASCII text converter.
// Each accepted item is a VALUE_WIDTH-bit two's-complement integer; the block sends its
// decimal text one character per output item, most significant first, with a leading
// minus sign for negative values, no leading zeros, and last set on the final character.
// The magnitude is shifted one bit per cycle into a row of decimal digit cells; the row
// then shifts out one digit position per cycle, holding while a stalled output character
// waits, with leading zero positions dropped; a negative value sends the sign first.
// A new item is taken while the final character of the previous one still waits.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sitda_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                         char_valid,
    input  logic                         char_stall,
    output logic [sitda_pkg::CHAR_W-1:0] char_code,
    output logic                         last
);

    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam int DIG_W = $clog2(NUM_DIGITS);

    sitda_pkg::state_t state_reg;
    sitda_pkg::state_t state_next;

    logic                         neg_reg;
    logic [VALUE_WIDTH-1:0]       mag_reg;
    logic [VALUE_WIDTH-1:0]       mag_in;
    logic [CNT_W-1:0]             count_reg;
    logic [DIG_W-1:0]             idx_reg;
    logic                         started_reg;
    logic                         char_valid_reg;
    logic [sitda_pkg::CHAR_W-1:0] char_code_reg;
    logic                         last_reg;

    logic                         item_take;
    logic                         out_free;
    logic                         conv_done;
    logic                         dig_last;
    logic                         load_char;
    logic [sitda_pkg::CHAR_W-1:0] load_code;
    logic                         load_last;
    sitda_pkg::cell_ctrl_t        cell_ctrl;

    logic                          bit_chain [NUM_DIGITS+1];
    logic [sitda_pkg::DIGIT_W-1:0] cell_digit [NUM_DIGITS];
    logic [sitda_pkg::DIGIT_W-1:0] top_digit;

    assign item_take = item_valid && (state_reg == sitda_pkg::S_IDLE);
    assign out_free = !char_valid_reg || !char_stall;
    assign conv_done = (count_reg == CNT_W'(VALUE_WIDTH - 1));
    assign dig_last = (idx_reg == DIG_W'(NUM_DIGITS - 1));
    assign top_digit = cell_digit[NUM_DIGITS-1];
    assign bit_chain[0] = mag_reg[VALUE_WIDTH-1];

    always_comb
    begin
        mag_in = $unsigned(value);
        if (value[VALUE_WIDTH-1])
        begin
            mag_in = ~mag_in + 1'b1;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++)
        begin : g_cell
            logic [sitda_pkg::DIGIT_W-1:0] lower_digit;
            if (gi == 0)
            begin : g_first
                assign lower_digit = '0;
            end
            else
            begin : g_rest
                assign lower_digit = cell_digit[gi-1];
            end
            sitda_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl),
                .bit_in   (bit_chain[gi]),
                .bit_out  (bit_chain[gi+1]),
                .digit_in (lower_digit),
                .digit    (cell_digit[gi])
            );
        end
    endgenerate

    always_comb
    begin
        cell_ctrl = '0;
        load_char = 1'b0;
        load_code = sitda_pkg::ASCII_ZERO;
        load_last = 1'b0;
        case (state_reg)
            sitda_pkg::S_IDLE:
            begin
                cell_ctrl.clear = item_take;
            end
            sitda_pkg::S_CONV:
            begin
                cell_ctrl.dabble = 1'b1;
            end
            sitda_pkg::S_SIGN:
            begin
                load_char = out_free;
                load_code = sitda_pkg::ASCII_MINUS;
            end
            sitda_pkg::S_EMIT:
            begin
                if ((top_digit == '0) && !started_reg && !dig_last)
                begin
                    cell_ctrl.shift = 1'b1;
                end
                else if (out_free)
                begin
                    cell_ctrl.shift = 1'b1;
                    load_char = 1'b1;
                    load_code = sitda_pkg::ASCII_ZERO + {3'b000, top_digit};
                    load_last = dig_last;
                end
            end
            default:
            begin
                cell_ctrl = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sitda_pkg::S_IDLE:
            begin
                if (item_take)
                begin
                    state_next = sitda_pkg::S_CONV;
                end
            end
            sitda_pkg::S_CONV:
            begin
                if (conv_done)
                begin
                    state_next = neg_reg ? sitda_pkg::S_SIGN : sitda_pkg::S_EMIT;
                end
            end
            sitda_pkg::S_SIGN:
            begin
                if (out_free)
                begin
                    state_next = sitda_pkg::S_EMIT;
                end
            end
            sitda_pkg::S_EMIT:
            begin
                if (cell_ctrl.shift && dig_last)
                begin
                    state_next = sitda_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sitda_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sitda_pkg::S_IDLE;
            count_reg <= '0;
            idx_reg <= '0;
            started_reg <= 1'b0;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (item_take)
            begin
                count_reg <= '0;
                idx_reg <= '0;
                started_reg <= 1'b0;
            end
            else
            begin
                if (state_reg == sitda_pkg::S_CONV)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (cell_ctrl.shift)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (load_char && (state_reg == sitda_pkg::S_EMIT))
                begin
                    started_reg <= 1'b1;
                end
            end
            if (load_char)
            begin
                char_valid_reg <= 1'b1;
            end
            else if (!char_stall)
            begin
                char_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            neg_reg <= value[VALUE_WIDTH-1];
            mag_reg <= mag_in;
        end
        else if (state_reg == sitda_pkg::S_CONV)
        begin
            mag_reg <= {mag_reg[VALUE_WIDTH-2:0], 1'b0};
        end
        if (load_char)
        begin
            char_code_reg <= load_code;
            last_reg <= load_last;
        end
    end

    assign item_stall = (state_reg != sitda_pkg::S_IDLE);
    assign char_valid = char_valid_reg;
    assign char_code = char_code_reg;
    assign last = last_reg;

`ifndef NO_ASSERTIONS
    a_take_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> state_reg == sitda_pkg::S_CONV)
        else $error("Accepted item did not start conversion.");

    a_no_digit_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sitda_pkg::S_CONV) |-> !bit_chain[NUM_DIGITS])
        else $error("Digit row overflowed during conversion.");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid_reg |-> (char_code_reg == sitda_pkg::ASCII_MINUS) ||
            ((char_code_reg >= sitda_pkg::ASCII_ZERO) &&
             (char_code_reg <= sitda_pkg::ASCII_NINE)))
        else $error("Output character is neither a digit nor a minus sign.");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid_reg && (char_code_reg == sitda_pkg::ASCII_MINUS)) |-> !last_reg)
        else $error("Minus sign flagged as the final character.");

    a_conv_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sitda_pkg::S_CONV) && conv_done) |=>
            (state_reg == sitda_pkg::S_SIGN) || (state_reg == sitda_pkg::S_EMIT))
        else $error("Conversion did not end after the full bit count.");
`endif

endmodule
